[sv/gauss_seidel_3x3_solver_unit_defines.svh]
// Assertion macros for the Gauss-Seidel solver
`ifndef GAUSS_SEIDEL_3X3_SOLVER_UNIT_DEFINES_SVH
`define GAUSS_SEIDEL_3X3_SOLVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GS_ASSERT(label, clk, rst, prop, msg)
`define GS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[sv/gs3_pkg.sv]
package gs3_pkg;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned CNT_W  = 16;
   localparam int unsigned ROW_W  = 2;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [ROW_W-1:0] ROW_LAST    = 2'd2;
   localparam logic [ROW_W-1:0] ROW_INVALID = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 1'b1;

   typedef struct packed {
      logic [ROW_W-1:0]         row;
      logic signed [WORD_W-1:0] coef_first;
      logic signed [WORD_W-1:0] coef_second;
      logic signed [WORD_W-1:0] coef_third;
      logic signed [WORD_W-1:0] rhs;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] sol_first;
      logic signed [WORD_W-1:0] sol_second;
      logic signed [WORD_W-1:0] sol_third;
      logic [CNT_W-1:0]         sweeps_used;
      logic                     converged;
      logic                     zero_pivot;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

[sv/gs3_if.sv]
interface gs3_req_if;
   logic             valid;
   logic             ready;
   gs3_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface gs3_rsp_if;
   logic             valid;
   logic             ready;
   gs3_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[sv/gs3_div.sv]
`include "gauss_seidel_3x3_solver_unit_defines.svh"
module gs3_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  num,
   input  logic signed [31:0]  den,
   output gs3_pkg::div_ctl_type ctl,
   output logic signed [31:0]  quo
);
   logic [63:0] rem_ff, rem_in, q_ff, q_in;
   logic [31:0] d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;
   logic [63:0] rem_sh;
   logic [63:0] qs;
   logic signed [64:0] qv;

   always_comb begin
      rem_in = rem_ff; q_in = q_ff; d_in = d_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; busy_in = busy_ff; done_in = 1'b0;
      rem_sh = {rem_ff[62:0], q_ff[63]};
      trial = {1'b0, rem_sh} - {33'd0, d_ff};
      if (start) begin
         rem_in = 64'd0;
         q_in = num[63] ? 64'(-num) : 64'(num);
         d_in = den[31] ? 32'(-den) : 32'(den);
         neg_in = num[63] ^ den[31];
         cnt_in = 7'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; q_ff <= q_in; d_ff <= d_in; cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   always_comb begin
      qs = q_ff;
      qv = neg_ff ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
      if (qv > 65'sd2147483647) quo = 32'sh7FFFFFFF;
      else if (qv < -65'sd2147483648) quo = 32'sh80000000;
      else quo = qv[31:0];
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = done_ff;

   `GS_ASSERT(a_div_no_restart, clock, reset, busy_ff |-> !start, "divider restarted while busy")
   `GS_ASSERT(a_div_done_end, clock, reset, done_ff |-> $past(busy_ff), "done without busy")
   `GS_ASSERT(a_div_done_idle, clock, reset, done_ff |-> !busy_ff, "done while busy")
endmodule

[sv/gauss_seidel_3x3_solver_unit.sv]
// A zero diagonal or a zero iteration limit answers through ST_CHECK and ST_OUT.
// A solve runs on one shared 64-step divider, three divisions per sweep, each
// through ST_MUL1 and ST_MUL2 (multiply-subtract), ST_DIV (divider start) and
// ST_WAIT until the divider is done, plus one ST_EVAL step per sweep.
// Rows 0 and 1 are only stored; no transaction is accepted during a solve.
// Reset: synchronous, active high; limit 200, tolerance 3, no result pending.
`include "gauss_seidel_3x3_solver_unit_defines.svh"
module gauss_seidel_3x3_solver_unit #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   gs3_req_if.sink     req,
   gs3_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_MUL1, ST_MUL2, ST_DIV, ST_WAIT, ST_EVAL, ST_OUT
   } state_type;

   state_type state_ff;
   logic signed [31:0] mem_ff [12];
   logic signed [31:0] x_ff [3];
   logic signed [31:0] px_ff [3];
   logic [15:0] lim_ff, tol_ff, swp_ff;
   logic [1:0]  idx_ff;
   logic        small_ff, conv_ff, piv_ff, rvalid_ff;
   logic signed [63:0] num_ff, prod_ff;
   logic signed [31:0] ca, xa, cb, xb, rh, dg, quo;
   logic signed [63:0] sub_y, sub_r;
   logic signed [64:0] sub_w;
   logic signed [32:0] diff;
   logic        small_now, div_go;
   gs3_pkg::div_ctl_type dctl;

   always_comb begin
      unique case (idx_ff)
         2'd0: begin
            ca = mem_ff[1]; xa = x_ff[1]; cb = mem_ff[2]; xb = x_ff[2];
            rh = mem_ff[3]; dg = mem_ff[0];
         end
         2'd1: begin
            ca = mem_ff[6]; xa = x_ff[2]; cb = mem_ff[4]; xb = x_ff[0];
            rh = mem_ff[7]; dg = mem_ff[5];
         end
         default: begin
            ca = mem_ff[8]; xa = x_ff[0]; cb = mem_ff[9]; xb = x_ff[1];
            rh = mem_ff[11]; dg = mem_ff[10];
         end
      endcase
   end

   assign sub_y = prod_ff;
   assign sub_w = {num_ff[63], num_ff} - {sub_y[63], sub_y};
   always_comb begin
      if (sub_w[64] != sub_w[63]) sub_r = sub_w[64] ? 64'sh8000000000000000
                                                   : 64'sh7FFFFFFFFFFFFFFF;
      else sub_r = sub_w[63:0];
   end

   assign diff = {quo[31], quo} - {px_ff[idx_ff][31], px_ff[idx_ff]};
   assign small_now = (diff[32] ? 33'(-diff) : diff) < {17'd0, tol_ff};
   assign div_go = (state_ff == ST_DIV);

   gs3_div u_div (
      .clock(clock), .reset(reset), .start(div_go),
      .num(sub_r), .den(dg), .ctl(dctl), .quo(quo)
   );

   assign req.ready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign rsp.valid = rvalid_ff;
   assign rsp.payload = '{sol_first: x_ff[0], sol_second: x_ff[1], sol_third: x_ff[2],
                          sweeps_used: swp_ff, converged: conv_ff, zero_pivot: piv_ff};

   always_ff @(posedge clock) begin
      if (req.valid && req.ready && req.payload.row != gs3_pkg::ROW_INVALID) begin
         mem_ff[{req.payload.row, 2'd0}] <= req.payload.coef_first;
         mem_ff[{req.payload.row, 2'd1}] <= req.payload.coef_second;
         mem_ff[{req.payload.row, 2'd2}] <= req.payload.coef_third;
         mem_ff[{req.payload.row, 2'd3}] <= req.payload.rhs;
      end
      if (reset) begin
         state_ff <= ST_IDLE; rvalid_ff <= 1'b0;
         lim_ff <= 16'd200; tol_ff <= 16'd3;
         idx_ff <= 2'd0; swp_ff <= 16'd0; conv_ff <= 1'b0; piv_ff <= 1'b0;
         small_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            x_ff[i] <= 32'sd0; px_ff[i] <= 32'sd0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               gs3_pkg::CSR_ITER_LIMIT: lim_ff <= csr_wdata;
               gs3_pkg::CSR_TOLERANCE:  tol_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) rvalid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready && req.payload.row == gs3_pkg::ROW_LAST) begin
                  state_ff <= ST_CHECK;
                  for (int i = 0; i < 3; i++) begin
                     x_ff[i] <= 32'sd0; px_ff[i] <= 32'sd0;
                  end
                  swp_ff <= 16'd0; conv_ff <= 1'b0; piv_ff <= 1'b0; idx_ff <= 2'd0;
               end
            end
            ST_CHECK: begin
               if (mem_ff[0] == 0 || mem_ff[5] == 0 || mem_ff[10] == 0) begin
                  piv_ff <= 1'b1; state_ff <= ST_OUT;
               end else if (lim_ff == 16'd0) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_MUL1;
               end
            end
            ST_MUL1: begin
               num_ff <= 64'(rh) <<< FRAC_BITS;
               prod_ff <= 64'(ca) * 64'(xa);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               num_ff <= sub_r;
               prod_ff <= 64'(cb) * 64'(xb);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               num_ff <= sub_r;
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (dctl.done) begin
                  x_ff[idx_ff] <= quo;
                  if (idx_ff == 2'd0) small_ff <= small_now;
                  else small_ff <= small_ff && small_now;
                  if (idx_ff == 2'd2) begin
                     idx_ff <= 2'd0; state_ff <= ST_EVAL;
                     swp_ff <= swp_ff + 16'd1;
                  end else begin
                     idx_ff <= idx_ff + 2'd1; state_ff <= ST_MUL1;
                  end
               end
            end
            ST_EVAL: begin
               for (int i = 0; i < 3; i++) px_ff[i] <= x_ff[i];
               if (small_ff) begin
                  conv_ff <= 1'b1; state_ff <= ST_OUT;
               end else if (swp_ff == lim_ff) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_MUL1;
               end
            end
            ST_OUT: begin
               rvalid_ff <= 1'b1; state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `GS_ASSERT(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE) |-> !req.ready, "accept during solve")
   `GS_ASSERT(a_out_once, clock, reset, (state_ff == ST_OUT) |=> rvalid_ff, "result not raised")
   `GS_ASSERT(a_conv_piv, clock, reset, rvalid_ff |-> !(conv_ff && piv_ff), "converged with zero pivot")
   `GS_ASSERT(a_sweep_limit, clock, reset, rvalid_ff |-> (swp_ff <= lim_ff), "sweeps beyond limit")
endmodule

[bench/tb_gauss_seidel_3x3_solver_unit.sv]
`timescale 1ns / 1ps

module tb_gauss_seidel_3x3_solver_unit;
   localparam int FRAC = 16;
   localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
   localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   gs3_req_if req_if ();
   gs3_rsp_if rsp_if ();

   gauss_seidel_3x3_solver_unit uut (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   gs3_pkg::req_type pending_rows[$];
   gs3_pkg::rsp_type solutions_due[$];
   logic signed [31:0] coef_mirror[12];
   logic [15:0] sweep_limit;
   logic [15:0] change_tol;
   bit row_loaded[3];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_order = 0;
   int hold_seen = 0;
   int hold_left = 0;
   bit req_taken = 1'b0;
   int errors = 0;

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic longint sub_sat(longint x, longint y);
      logic signed [64:0] d;
      d = {x[63], x} - {y[63], y};
      if (d[64] != d[63]) return d[64] ? S64_MIN : S64_MAX;
      return d[63:0];
   endfunction

   function automatic logic signed [31:0] relax(logic signed [31:0] rhs,
         logic signed [31:0] p, logic signed [31:0] u, logic signed [31:0] q,
         logic signed [31:0] w, logic signed [31:0] diag);
      longint num;
      longint quo;
      num = longint'(rhs) * (64'sd1 <<< FRAC);
      num = sub_sat(num, longint'(p) * longint'(u));
      num = sub_sat(num, longint'(q) * longint'(w));
      if (num == S64_MIN && diag == -32'sd1) quo = S64_MAX;
      else quo = num / longint'(diag);
      if (quo > longint'(W_MAX)) return W_MAX;
      if (quo < longint'(W_MIN)) return W_MIN;
      return quo[31:0];
   endfunction

   function automatic longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic gs3_pkg::rsp_type solve_system();
      gs3_pkg::rsp_type r;
      logic signed [31:0] x[3];
      logic signed [31:0] prev[3];
      longint tol;
      r = '0;
      x = '{default: '0};
      prev = '{default: '0};
      tol = longint'(change_tol);
      if (coef_mirror[0] == 0 || coef_mirror[5] == 0 || coef_mirror[10] == 0) begin
         r.zero_pivot = 1'b1;
         return r;
      end
      for (int i = 1; i <= int'(sweep_limit); i++) begin
         x[0] = relax(coef_mirror[3], coef_mirror[1], x[1], coef_mirror[2], x[2],
                      coef_mirror[0]);
         x[1] = relax(coef_mirror[7], coef_mirror[6], x[2], coef_mirror[4], x[0],
                      coef_mirror[5]);
         x[2] = relax(coef_mirror[11], coef_mirror[8], x[0], coef_mirror[9], x[1],
                      coef_mirror[10]);
         r.sweeps_used = i[15:0];
         if (mag(longint'(x[0]) - longint'(prev[0])) < tol &&
             mag(longint'(x[1]) - longint'(prev[1])) < tol &&
             mag(longint'(x[2]) - longint'(prev[2])) < tol) begin
            r.converged = 1'b1;
            break;
         end
         prev = x;
      end
      r.sol_first = x[0];
      r.sol_second = x[1];
      r.sol_third = x[2];
      return r;
   endfunction

   task automatic field_check(string name, longint e, longint a);
      if (e != a) begin
         errors++;
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      end
   endtask

   // monitor: track config, predict on input transactions, check results
   always @(posedge clock) begin
      gs3_pkg::req_type t;
      gs3_pkg::rsp_type e;
      gs3_pkg::rsp_type a;
      if (reset) begin
         sweep_limit <= 16'd200;
         change_tol <= 16'd3;
         req_taken <= 1'b0;
         solutions_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               gs3_pkg::CSR_ITER_LIMIT: sweep_limit <= csr_wdata;
               gs3_pkg::CSR_TOLERANCE: change_tol <= csr_wdata;
               default: ;
            endcase
         end
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            t = req_if.payload;
            if (t.row != gs3_pkg::ROW_INVALID) begin
               coef_mirror[t.row * 4 + 0] = t.coef_first;
               coef_mirror[t.row * 4 + 1] = t.coef_second;
               coef_mirror[t.row * 4 + 2] = t.coef_third;
               coef_mirror[t.row * 4 + 3] = t.rhs;
               if (t.row == gs3_pkg::ROW_LAST) solutions_due.push_back(solve_system());
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            a = rsp_if.payload;
            if (solutions_due.size() == 0) begin
               errors++;
               $display("%0t unexpected result transaction: %p", $time, a);
            end else begin
               e = solutions_due.pop_front();
               field_check("sol_first", e.sol_first, a.sol_first);
               field_check("sol_second", e.sol_second, a.sol_second);
               field_check("sol_third", e.sol_third, a.sol_third);
               field_check("sweeps_used", e.sweeps_used, a.sweeps_used);
               field_check("converged", e.converged, a.converged);
               field_check("zero_pivot", e.zero_pivot, a.zero_pivot);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_rows.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.payload <= pending_rows.pop_front();
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_order != hold_seen) begin
         hold_seen = hold_order;
         hold_left = 3000;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   task automatic push_row(logic [1:0] r, logic signed [31:0] a, logic signed [31:0] b,
                           logic signed [31:0] c, logic signed [31:0] d);
      gs3_pkg::req_type t;
      t.row = r;
      t.coef_first = a;
      t.coef_second = b;
      t.coef_third = c;
      t.rhs = d;
      pending_rows.push_back(t);
      if (r != gs3_pkg::ROW_INVALID) row_loaded[r] = 1'b1;
   endtask

   function automatic logic signed [31:0] wild_word();
      case ($urandom_range(5))
         0: return W_MAX;
         1: return W_MIN;
         2: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // kind 0: diagonally dominant, 1: full range, 2: dominant with a zero diagonal
   task automatic push_system(int kind);
      logic signed [31:0] m[12];
      int zpos;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 4; k++) begin
            if (kind == 1) m[r * 4 + k] = wild_word();
            else if (k == r) begin
               m[r * 4 + k] = $urandom_range(8 * 65536, 4 * 65536);
               if ($urandom_range(1)) m[r * 4 + k] = -m[r * 4 + k];
            end else if (k == 3) m[r * 4 + k] = $signed($urandom_range(32 * 65536)) - 16 * 65536;
            else m[r * 4 + k] = $signed($urandom_range(2 * 65536)) - 65536;
         end
      end
      if (kind == 2) begin
         zpos = $urandom_range(2);
         m[zpos * 5] = '0;
      end
      if ($urandom_range(3) == 0) begin
         push_row(2'd1, m[4], m[5], m[6], m[7]);
         push_row(2'd0, m[0], m[1], m[2], m[3]);
      end else begin
         push_row(2'd0, m[0], m[1], m[2], m[3]);
         push_row(2'd1, m[4], m[5], m[6], m[7]);
      end
      push_row(gs3_pkg::ROW_LAST, m[8], m[9], m[10], m[11]);
   endtask

   task automatic push_noise();
      logic [1:0] r;
      r = $urandom_range(3);
      if (r == gs3_pkg::ROW_LAST && !(row_loaded[0] && row_loaded[1])) r = 2'd0;
      push_row(r, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic drain();
      while (pending_rows.size() > 0 || req_if.valid || solutions_due.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_limits(logic [15:0] limit, logic [15:0] tol);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= gs3_pkg::CSR_ITER_LIMIT;
      csr_wdata <= limit;
      @(negedge clock);
      csr_index <= gs3_pkg::CSR_TOLERANCE;
      csr_wdata <= tol;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(logic [15:0] limit, logic [15:0] tol, int sidle, int rstall,
                            int count, bit bounded);
      int start;
      int pick;
      drain();
      set_limits(limit, tol);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      start = pending_rows.size();
      while (pending_rows.size() - start < count) begin
         pick = $urandom_range(99);
         if (pick < 70 || (bounded && pick < 90)) push_system(0);
         else if (pick < 85) push_system(1);
         else if (pick < 90 || bounded) push_system(2);
         else push_noise();
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset defaults: identity system, zero diagonals, ignored row, general system
      push_row(2'd0, ONE, 0, 0, 5 * ONE);
      push_row(2'd1, 0, ONE, 0, -3 * ONE);
      push_row(gs3_pkg::ROW_INVALID, W_MAX, W_MIN, -1, W_MAX);
      push_row(gs3_pkg::ROW_LAST, 0, 0, ONE, ONE);
      push_row(gs3_pkg::ROW_LAST, 0, 0, 0, ONE);
      push_row(2'd0, 0, ONE, ONE, ONE);
      push_row(gs3_pkg::ROW_LAST, 0, 0, ONE, ONE);
      push_row(2'd0, ONE, 0, 0, 5 * ONE);
      push_row(2'd1, 0, 0, 0, ONE);
      push_row(gs3_pkg::ROW_LAST, 0, 0, ONE, ONE);
      push_row(2'd1, ONE, 2 * ONE, ONE, ONE);
      push_row(gs3_pkg::ROW_LAST, ONE, ONE, 4 * ONE, W_MAX);

      drain();
      set_limits(16'd2, 16'd0);
      push_row(2'd0, W_MAX, W_MAX, W_MAX, W_MAX);
      push_row(2'd1, W_MIN, W_MIN, W_MIN, W_MIN);
      push_row(gs3_pkg::ROW_LAST, W_MIN, W_MIN, W_MIN, W_MIN);
      push_row(2'd0, -1, W_MAX, W_MAX, W_MIN);
      push_row(2'd1, W_MIN, -1, W_MIN, W_MIN);
      push_row(gs3_pkg::ROW_LAST, W_MAX, W_MAX, -1, W_MIN);
      push_row(gs3_pkg::ROW_LAST, W_MIN, W_MIN, 1, W_MAX);

      drain();
      set_limits(16'd0, 16'd65535);
      push_system(0);
      push_system(1);

      run_phase(16'd3, 16'd3, 0, 0, 250, 1'b0);
      hold_order++;
      run_phase(16'd1, 16'd0, 59, 0, 200, 1'b0);
      run_phase(16'd6, 16'($urandom), 0, 59, 200, 1'b0);
      run_phase(16'd0, 16'd65535, 38, 38, 150, 1'b0);
      run_phase(16'd65535, 16'd65535, 59, 59, 100, 1'b1);
      hold_order++;
      run_phase(16'd2, 16'd100, 38, 38, 150, 1'b0);
      run_phase(16'd4, 16'($urandom), 0, 0, 150, 1'b0);

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("gauss_seidel_3x3_solver_unit verification clean");
      else $display("gauss_seidel_3x3_solver_unit verification failed");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("gauss_seidel_3x3_solver_unit verification failed");
      $finish;
   end
endmodule

[gauss_seidel_3x3_solver_unit.f]
+incdir+sv
sv/gs3_pkg.sv
sv/gs3_if.sv
sv/gs3_div.sv
sv/gauss_seidel_3x3_solver_unit.sv
bench/tb_gauss_seidel_3x3_solver_unit.sv
